// File: rtl/ksub_pkg.sv
// shared constants and types for the k-subset enumerator
package ksub_pkg;

  localparam int MAX_N     = 16;
  localparam int MW        = MAX_N + 1;
  localparam int IDX_W     = $clog2(MAX_N);
  localparam int CNT_W     = 14;
  localparam int CFG_W     = 5;
  localparam int N_W       = CFG_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SIZE    = 2'd0,
    REG_SUBSET_SIZE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_N-1:0] mask;
    logic [CNT_W-1:0] number;
    logic             exhausted;
  } ksub_cmd_t;

endpackage

// File: rtl/k_subset_enumerator.sv
// top level of the k-subset enumerator
//
//   port group   dir  carries
//   in_*         in   restart request, one per subset or exhausted word
//   out_*        out  subset_number, position, element_index, last_of_subset, exhausted
//   cfg_*        in   register index and data, always ready
//
// the front takes a request whenever the queue has room; the back loads a
// command and then emits one word per element, at most MAX_N of them (a single
// word when exhausted), and loads the next command only after its last word
// a two-entry queue lets the front take requests while the back is stalled
// rst is synchronous and clears state and registers to their defaults
module k_subset_enumerator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ksub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ksub_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ksub_pkg::CNT_W-1:0]     subset_number,
  output logic [ksub_pkg::IDX_W-1:0]     position,
  output logic [ksub_pkg::IDX_W-1:0]     element_index,
  output logic                           last_of_subset,
  output logic                           exhausted
);
  import ksub_pkg::*;

  ksub_cmd_t push_cmd;
  ksub_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;

  ksub_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  ksub_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .not_empty (q_not_empty)
  );

  ksub_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_data         (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .subset_number  (subset_number),
    .position       (position),
    .element_index  (element_index),
    .last_of_subset (last_of_subset),
    .exhausted      (exhausted)
  );

  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |->
      subset_number == '0 && position == '0 && element_index == '0 && !last_of_subset)
    else $error("exhausted word carries nonzero fields");

  a_idx_ge_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !exhausted |-> element_index >= position)
    else $error("element index below its position");

  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !exhausted && !last_of_subset |=> out_valid)
    else $error("subset run broken before last element");

  a_next_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !exhausted && !last_of_subset |=>
      position == $past(position) + IDX_W'(1) && element_index > $past(element_index))
    else $error("element order broken within subset");

endmodule

// File: rtl/ksub_front.sv
// front end: config registers, subset state and next-combination step
module ksub_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ksub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ksub_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  input  logic                           q_full,
  output logic                           push,
  output ksub_pkg::ksub_cmd_t            cmd
);
  import ksub_pkg::*;

  logic [CFG_W-1:0] set_size;
  logic [CFG_W-1:0] subset_size;
  logic [MW-1:0]    mask;
  logic [MW-1:0]    mask_next;
  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  logic             started;
  logic             started_next;
  logic             done;
  logic             done_next;

  logic [N_W-1:0]   eff_n;
  logic [MW-1:0]    low;
  logic [MW-1:0]    ripple;
  logic [MW-1:0]    run;
  logic [MW-1:0]    refill;
  logic [MW-1:0]    nx;
  logic [MW-1:0]    high_mask;
  logic [MW-1:0]    first_mask;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    eff_n = (N_W'(set_size) > N_W'(MAX_N)) ? N_W'(MAX_N) : N_W'(set_size);
    low    = mask & (~mask + MW'(1));
    ripple = mask + low;
    run    = (mask ^ ripple) >> 2;
    refill = '0;
    for (int i = 0; i < MW; i++) begin
      if (low[i]) begin
        refill = refill | (run >> i);
      end
    end
    nx = ripple | refill;
    for (int b = 0; b < MW; b++) begin
      high_mask[b]  = N_W'(b) >= eff_n;
      first_mask[b] = N_W'(b) < N_W'(subset_size);
    end
  end

  always_comb begin
    mask_next     = mask;
    counter_next  = counter;
    started_next  = started;
    done_next     = done;
    cmd.mask      = '0;
    cmd.number    = '0;
    cmd.exhausted = 1'b1;
    if (restart || !started) begin
      started_next = 1'b1;
      counter_next = '0;
      if (subset_size == '0 || N_W'(subset_size) > eff_n) begin
        mask_next = '0;
        done_next = 1'b1;
      end else begin
        mask_next     = first_mask;
        done_next     = 1'b0;
        cmd.mask      = first_mask[MAX_N-1:0];
        cmd.exhausted = 1'b0;
      end
    end else if (done || mask == '0) begin
      cmd.exhausted = 1'b1;
    end else if ((nx & high_mask) != '0) begin
      done_next = 1'b1;
    end else begin
      mask_next     = nx;
      counter_next  = counter + CNT_W'(1);
      cmd.mask      = nx[MAX_N-1:0];
      cmd.number    = counter + CNT_W'(1);
      cmd.exhausted = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= CFG_W'(16);
      subset_size <= CFG_W'(1);
      mask        <= '0;
      counter     <= '0;
      started     <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SET_SIZE:    set_size <= cfg_data;
          REG_SUBSET_SIZE: subset_size <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        mask    <= mask_next;
        counter <= counter_next;
        started <= started_next;
        done    <= done_next;
      end
    end
  end

endmodule

// File: rtl/ksub_queue.sv
// small command queue between front and back
module ksub_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ksub_pkg::ksub_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output ksub_pkg::ksub_cmd_t pop_data,
  output logic                not_empty
);
  import ksub_pkg::*;

  ksub_cmd_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// File: rtl/ksub_back.sv
// back end: walks a subset mask and emits one element per word
module ksub_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_not_empty,
  input  ksub_pkg::ksub_cmd_t        q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ksub_pkg::CNT_W-1:0] subset_number,
  output logic [ksub_pkg::IDX_W-1:0] position,
  output logic [ksub_pkg::IDX_W-1:0] element_index,
  output logic                       last_of_subset,
  output logic                       exhausted
);
  import ksub_pkg::*;

  logic             busy;
  logic [MAX_N-1:0] rem;
  logic [CNT_W-1:0] number;
  logic [IDX_W-1:0] pos;
  logic             exh;
  logic             adv;
  logic [IDX_W-1:0] low_idx;
  logic [MAX_N-1:0] low_bit;
  logic             is_last;

  always_comb begin
    low_idx = '0;
    for (int i = MAX_N - 1; i >= 0; i--) begin
      if (rem[i]) begin
        low_idx = IDX_W'(i);
      end
    end
    low_bit = rem & (~rem + MAX_N'(1));
    is_last = exh || ((rem & ~low_bit) == '0);
  end

  assign pop = !busy && q_not_empty;
  assign adv = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && is_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem    <= q_data.mask;
      number <= q_data.number;
      exh    <= q_data.exhausted;
      pos    <= '0;
    end else if (adv) begin
      rem <= rem & ~low_bit;
      pos <= pos + IDX_W'(1);
    end
    if (adv) begin
      subset_number  <= exh ? '0 : number;
      position       <= exh ? '0 : pos;
      element_index  <= exh ? '0 : low_idx;
      last_of_subset <= !exh && is_last;
      exhausted      <= exh;
    end
  end

endmodule
